@@ hdl/priority_queue_array_unit_assert.svh @@
// Assertion macros used by the priority queue top level.
// Both macros expect signals named clock and reset in the scope where they are used.
`ifndef PRIORITY_QUEUE_ARRAY_UNIT_ASSERT_SVH
`define PRIORITY_QUEUE_ARRAY_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PQA_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PQA_ASSERT_NXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ hdl/pqa_pkg.sv @@
// Package for the priority queue: sizes, request and status codes, scan structs.
// It has no dependencies. Every RTL file of the block uses it.
`timescale 1ns / 1ps

package pqa_pkg;

   localparam int DEPTH      = 8;
   localparam int PRIO_WIDTH = 8;
   localparam int ITEM_W     = 32;
   localparam int IDX_W      = $clog2(DEPTH);
   localparam int CNT_W      = $clog2(DEPTH + 1);

   localparam logic [1:0] REQ_INSERT = 2'd0;
   localparam logic [1:0] REQ_REMOVE = 2'd1;
   localparam logic [1:0] REQ_PEEK   = 2'd2;

   localparam logic [1:0] STAT_OK        = 2'd0;
   localparam logic [1:0] STAT_OVERFLOW  = 2'd1;
   localparam logic [1:0] STAT_UNDERFLOW = 2'd2;

   // One slot presented to the shared comparator.
   typedef struct packed {
      logic                  step;
      logic                  slot_valid;
      logic [PRIO_WIDTH-1:0] prio;
      logic [IDX_W-1:0]      idx;
   } scan_step_type;

   // Running outcome of a scan.
   typedef struct packed {
      logic             found;
      logic [IDX_W-1:0] idx;
   } scan_result_type;

endpackage

@@ hdl/pqa_slot_store.sv @@
// Slot storage of the priority queue: item and priority memories, one read port.
// Depends on pqa_pkg.
`timescale 1ns / 1ps

module pqa_slot_store (
   input  logic                               clock,
   input  logic                               wr_en,
   input  logic [pqa_pkg::IDX_W-1:0]          wr_addr,
   input  logic [pqa_pkg::ITEM_W-1:0]         wr_item,
   input  logic [pqa_pkg::PRIO_WIDTH-1:0]     wr_prio,
   input  logic [pqa_pkg::IDX_W-1:0]          rd_addr,
   output logic [pqa_pkg::ITEM_W-1:0]         rd_item,
   output logic [pqa_pkg::PRIO_WIDTH-1:0]     rd_prio
);

   logic [pqa_pkg::ITEM_W-1:0]     item_mem_ff [pqa_pkg::DEPTH];
   logic [pqa_pkg::PRIO_WIDTH-1:0] prio_mem_ff [pqa_pkg::DEPTH];
   logic [pqa_pkg::ITEM_W-1:0]     rd_item_ff;
   logic [pqa_pkg::PRIO_WIDTH-1:0] rd_prio_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         item_mem_ff[wr_addr] <= wr_item;
         prio_mem_ff[wr_addr] <= wr_prio;
      end
   end

   // Registered read; the address is held while the data is needed.
   always_ff @(posedge clock) begin
      rd_item_ff <= item_mem_ff[rd_addr];
      rd_prio_ff <= prio_mem_ff[rd_addr];
   end

   assign rd_item = rd_item_ff;
   assign rd_prio = rd_prio_ff;

endmodule

@@ hdl/pqa_scan_unit.sv @@
// Shared comparator of the priority queue: looks at one slot per cycle and keeps
// the first free slot or the highest-priority valid slot. Depends on pqa_pkg.
`timescale 1ns / 1ps

module pqa_scan_unit (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     clear,
   input  logic                     find_free,
   input  pqa_pkg::scan_step_type   slot,
   output pqa_pkg::scan_result_type result
);

   logic                           found_ff;
   logic                           found_in;
   logic [pqa_pkg::IDX_W-1:0]      best_idx_ff;
   logic [pqa_pkg::IDX_W-1:0]      best_idx_in;
   logic [pqa_pkg::PRIO_WIDTH-1:0] best_prio_ff;
   logic [pqa_pkg::PRIO_WIDTH-1:0] best_prio_in;
   logic                           take;

   // A strict greater-than keeps the lowest slot on equal priorities.
   always_comb begin
      if (find_free) begin
         take = !slot.slot_valid && !found_ff;
      end else begin
         take = slot.slot_valid && (!found_ff || (slot.prio > best_prio_ff));
      end
   end

   always_comb begin
      found_in     = found_ff;
      best_idx_in  = best_idx_ff;
      best_prio_in = best_prio_ff;
      if (clear) begin
         found_in = 1'b0;
      end else if (slot.step && take) begin
         found_in     = 1'b1;
         best_idx_in  = slot.idx;
         best_prio_in = slot.prio;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff <= 1'b0;
      end else begin
         found_ff <= found_in;
      end
      best_idx_ff  <= best_idx_in;
      best_prio_ff <= best_prio_in;
   end

   assign result.found = found_ff;
   assign result.idx   = best_idx_ff;

endmodule

@@ hdl/priority_queue_array_unit.sv @@
// Top level of the fixed-slot priority queue: sequencer, slot valid bits, count
// and result register. Depends on pqa_pkg, pqa_slot_store, pqa_scan_unit and
// priority_queue_array_unit_assert.svh.
//
//   Channel   Direction  Handshake             Payload
//   req       in         req_valid/req_stall   req_type, req_priority_req, req_item_in
//   rsp       out        rsp_valid/rsp_stall   rsp_item_out, rsp_status, rsp_occupancy
//
// In every transaction, one shared comparator visits the slots one per cycle through
// the single registered read port of the slot memory, then a drain state lets that
// read reach the comparator, a fetch state reads the winning item and a done state
// writes the result register and the slot state.
// Reset is synchronous and clears the valid bits, the count and both handshakes.
// A stalled result waits in its register; the next request is taken meanwhile and
// is held at its final step until the register frees up.
`timescale 1ns / 1ps
`include "priority_queue_array_unit_assert.svh"

module priority_queue_array_unit (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [1:0]                        req_type,
   input  logic [7:0]                        req_priority_req,
   input  logic signed [31:0]                req_item_in,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic signed [31:0]                rsp_item_out,
   output logic [1:0]                        rsp_status,
   output logic [3:0]                        rsp_occupancy
);

   // Scan, then a drain state to let the last slot read reach the comparator, then the
   // item read, then the result is committed.
   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_DRAIN,
      S_FETCH,
      S_DONE
   } state_type;

   localparam int IDX_W  = pqa_pkg::IDX_W;
   localparam int CNT_W  = pqa_pkg::CNT_W;
   localparam int PRIO_W = pqa_pkg::PRIO_WIDTH;

   state_type                  state_ff, state_in;
   logic [1:0]                 req_type_ff, req_type_in;
   logic [PRIO_W-1:0]          prio_ff, prio_in;
   logic [31:0]                item_ff, item_in;
   logic [IDX_W-1:0]           idx_ff, idx_in;
   logic                       pipe_vld_ff, pipe_vld_in;
   logic [IDX_W-1:0]           pipe_idx_ff, pipe_idx_in;
   logic                       pipe_slot_ff, pipe_slot_in;
   logic [pqa_pkg::DEPTH-1:0]  slot_valid_ff, slot_valid_in;
   logic [CNT_W-1:0]           count_ff, count_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [31:0]                rsp_item_ff, rsp_item_in;
   logic [1:0]                 rsp_status_ff, rsp_status_in;
   logic [3:0]                 rsp_occ_ff, rsp_occ_in;

   logic [PRIO_W+7:0]          prio_ext;
   logic [CNT_W+3:0]           occ_ext;
   logic                       scan_clear;
   logic                       load_rsp;
   logic                       wr_en;
   logic [IDX_W-1:0]           rd_addr;
   logic [31:0]                rd_item;
   logic [PRIO_W-1:0]          rd_prio;
   pqa_pkg::scan_step_type     scan_step;
   pqa_pkg::scan_result_type   scan_res;

   // Only the low PRIO_WIDTH bits of the requested priority are kept.
   assign prio_ext = {{PRIO_W{1'b0}}, req_priority_req};

   // During the scan the memory is read at the scan counter; afterwards it is held
   // at the winning slot so that the item stays put while the result waits.
   assign rd_addr = ((state_ff == S_FETCH) || (state_ff == S_DONE)) ? scan_res.idx : idx_ff;

   assign scan_step.step       = pipe_vld_ff;
   assign scan_step.slot_valid = pipe_slot_ff;
   assign scan_step.prio       = rd_prio;
   assign scan_step.idx        = pipe_idx_ff;

   pqa_slot_store u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (scan_res.idx),
      .wr_item (item_ff),
      .wr_prio (prio_ff),
      .rd_addr (rd_addr),
      .rd_item (rd_item),
      .rd_prio (rd_prio)
   );

   pqa_scan_unit u_scan (
      .clock     (clock),
      .reset     (reset),
      .clear     (scan_clear),
      .find_free (req_type_ff == pqa_pkg::REQ_INSERT),
      .slot      (scan_step),
      .result    (scan_res)
   );

   always_comb begin
      state_in      = state_ff;
      req_type_in   = req_type_ff;
      prio_in       = prio_ff;
      item_in       = item_ff;
      idx_in        = idx_ff;
      pipe_vld_in   = 1'b0;
      pipe_idx_in   = pipe_idx_ff;
      pipe_slot_in  = pipe_slot_ff;
      slot_valid_in = slot_valid_ff;
      count_in      = count_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_item_in   = rsp_item_ff;
      rsp_status_in = rsp_status_ff;
      scan_clear    = 1'b0;
      load_rsp      = 1'b0;
      wr_en         = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               req_type_in = req_type;
               prio_in     = prio_ext[PRIO_W-1:0];
               item_in     = req_item_in;
               idx_in      = '0;
               scan_clear  = 1'b1;
               state_in    = S_SCAN;
            end
         end
         S_SCAN: begin
            pipe_vld_in  = 1'b1;
            pipe_idx_in  = idx_ff;
            pipe_slot_in = slot_valid_ff[idx_ff];
            idx_in       = idx_ff + IDX_W'(1);
            if (idx_ff == IDX_W'(pqa_pkg::DEPTH - 1)) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            state_in = S_FETCH;
         end
         S_FETCH: begin
            state_in = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               load_rsp      = 1'b1;
               rsp_valid_in  = 1'b1;
               rsp_item_in   = '0;
               rsp_status_in = pqa_pkg::STAT_OK;
               state_in      = S_IDLE;
               case (req_type_ff)
                  pqa_pkg::REQ_INSERT: begin
                     if (scan_res.found) begin
                        wr_en                       = 1'b1;
                        slot_valid_in[scan_res.idx] = 1'b1;
                        count_in                    = count_ff + CNT_W'(1);
                     end else begin
                        rsp_status_in = pqa_pkg::STAT_OVERFLOW;
                     end
                  end
                  pqa_pkg::REQ_REMOVE: begin
                     if (scan_res.found) begin
                        rsp_item_in                 = rd_item;
                        slot_valid_in[scan_res.idx] = 1'b0;
                        count_in                    = count_ff - CNT_W'(1);
                     end else begin
                        rsp_status_in = pqa_pkg::STAT_UNDERFLOW;
                     end
                  end
                  pqa_pkg::REQ_PEEK: begin
                     if (scan_res.found) begin
                        rsp_item_in = rd_item;
                     end else begin
                        rsp_status_in = pqa_pkg::STAT_UNDERFLOW;
                     end
                  end
                  default: begin
                     // An unknown request leaves the queue alone and reports ok.
                     rsp_status_in = pqa_pkg::STAT_OK;
                  end
               endcase
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Occupancy is the count taken modulo 16.
   assign occ_ext    = {4'b0000, count_in};
   assign rsp_occ_in = load_rsp ? occ_ext[3:0] : rsp_occ_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         pipe_vld_ff   <= 1'b0;
         slot_valid_ff <= '0;
         count_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         pipe_vld_ff   <= pipe_vld_in;
         slot_valid_ff <= slot_valid_in;
         count_ff      <= count_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      req_type_ff   <= req_type_in;
      prio_ff       <= prio_in;
      item_ff       <= item_in;
      idx_ff        <= idx_in;
      pipe_idx_ff   <= pipe_idx_in;
      pipe_slot_ff  <= pipe_slot_in;
      rsp_item_ff   <= rsp_item_in;
      rsp_status_ff <= rsp_status_in;
      rsp_occ_ff    <= rsp_occ_in;
   end

   assign req_stall     = (state_ff != S_IDLE);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_item_out  = rsp_item_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_occupancy = rsp_occ_ff;

   `PQA_ASSERT_IMP(a_count_tracks_valid, 1'b1,
      (int'(count_ff) == $countones(slot_valid_ff)),
      "stored count disagrees with the slot valid bits")
   `PQA_ASSERT_IMP(a_overflow_only_full,
      (load_rsp && (rsp_status_in == pqa_pkg::STAT_OVERFLOW)),
      (count_ff == CNT_W'(pqa_pkg::DEPTH)),
      "overflow reported while a slot was free")
   `PQA_ASSERT_IMP(a_underflow_only_empty,
      (load_rsp && (rsp_status_in == pqa_pkg::STAT_UNDERFLOW)),
      (count_ff == '0),
      "underflow reported while the queue held items")
   `PQA_ASSERT_NXT(a_remove_drops_one,
      (load_rsp && (req_type_ff == pqa_pkg::REQ_REMOVE) && scan_res.found),
      (count_ff == ($past(count_ff) - CNT_W'(1))),
      "a successful remove did not lower the count by one")

endmodule

@@ dv/tb.sv @@
// Self-checking testbench for priority_queue_array_unit: directed and random
// requests are scored against a behavioral model of the slot array kept here.
// Depends on pqa_pkg and the RTL of the block.
`timescale 1ns / 1ps

module tb;

   // The request code that the block must ignore.
   localparam logic [1:0] REQ_UNUSED = 2'd3;

   localparam int RANDOM_REQUESTS = 400;
   localparam int LONG_HOLD_CYCLES = 250;
   localparam int SETTLE_CYCLES = 4 * (pqa_pkg::DEPTH + 4);

   typedef struct {
      logic [1:0]         kind;
      logic [7:0]         prio;
      logic signed [31:0] value;
      bit                 drain_first;   // Wait for every outstanding response first.
   } queue_request_type;

   typedef struct packed {
      logic signed [31:0] item;
      logic [1:0]         status;
      logic [3:0]         occupancy;
   } queue_response_type;

   logic                clock;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic [1:0]          req_type = pqa_pkg::REQ_PEEK;
   logic [7:0]          req_priority_req = '0;
   logic signed [31:0]  req_item_in = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic signed [31:0]  rsp_item_out;
   logic [1:0]          rsp_status;
   logic [3:0]          rsp_occupancy;

   queue_request_type   request_queue[$];
   queue_response_type  expected_responses[$];

   // Shadow copy of the slot array.
   logic signed [31:0]  slot_value[pqa_pkg::DEPTH];
   logic [pqa_pkg::PRIO_WIDTH-1:0] slot_prio[pqa_pkg::DEPTH];
   bit                  slot_busy[pqa_pkg::DEPTH];
   int                  held_count = 0;

   int                  sent_total = 0;
   int                  responses_done = 0;
   int                  error_count = 0;
   int                  kind_tally[4] = '{0, 0, 0, 0};
   int                  overflow_tally = 0;
   int                  underflow_tally = 0;
   int                  full_stall_cycles = 0;

   priority_queue_array_unit DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_type         (req_type),
      .req_priority_req (req_priority_req),
      .req_item_in      (req_item_in),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_item_out     (rsp_item_out),
      .rsp_status       (rsp_status),
      .rsp_occupancy    (rsp_occupancy)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Applies one request to the shadow slot array and returns the response the
   // block should give. Ties on priority go to the lowest slot index.
   function automatic queue_response_type apply_queue_request(
      input logic [1:0] kind,
      input logic [7:0] prio,
      input logic signed [31:0] value);
      queue_response_type resp;
      int slot;
      resp = '0;
      slot = -1;
      kind_tally[kind]++;
      case (kind)
         pqa_pkg::REQ_INSERT: begin
            for (int i = 0; i < pqa_pkg::DEPTH; i++)
               if (!slot_busy[i] && slot < 0) slot = i;
            if (slot >= 0) begin
               slot_value[slot] = value;
               slot_prio[slot] = prio[pqa_pkg::PRIO_WIDTH-1:0];
               slot_busy[slot] = 1'b1;
               held_count++;
            end else begin
               resp.status = pqa_pkg::STAT_OVERFLOW;
               overflow_tally++;
            end
         end
         pqa_pkg::REQ_REMOVE, pqa_pkg::REQ_PEEK: begin
            for (int i = 0; i < pqa_pkg::DEPTH; i++)
               if (slot_busy[i] && (slot < 0 || slot_prio[i] > slot_prio[slot])) slot = i;
            if (slot < 0) begin
               resp.status = pqa_pkg::STAT_UNDERFLOW;
               underflow_tally++;
            end else begin
               resp.item = slot_value[slot];
               if (kind == pqa_pkg::REQ_REMOVE) begin
                  slot_busy[slot] = 1'b0;
                  held_count--;
               end
            end
         end
         default: ;
      endcase
      resp.occupancy = 4'(held_count);
      return resp;
   endfunction

   task automatic queue_up(input logic [1:0] kind, input int prio,
                           input logic [31:0] value, input bit drain_first);
      queue_request_type r;
      r.kind = kind;
      r.prio = 8'(prio);
      r.value = value;
      r.drain_first = drain_first;
      request_queue.push_back(r);
   endtask

   task automatic report_field(input string name, input longint expected, input longint actual);
      $display("%0t ns: ERROR on %s, expected %0d, got %0d", $time, name, expected, actual);
      error_count++;
   endtask

   // Sender: offers queued requests in bursts separated by random gaps. The
   // model is updated at the edge where a transaction is accepted.
   int burst_left = 1;
   int gap_left = 0;

   always @(posedge clock) begin
      queue_request_type next;
      bit taken;
      bit all_back;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         taken = req_valid && !req_stall;
         if (taken) begin
            expected_responses.push_back(
               apply_queue_request(req_type, req_priority_req, req_item_in));
            sent_total <= sent_total + 1;
         end
         all_back = !taken && (sent_total == responses_done);
         if (!req_valid || taken) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (request_queue.size() == 0) begin
               req_valid <= 1'b0;
            end else if (request_queue[0].drain_first && !all_back) begin
               req_valid <= 1'b0;
            end else begin
               next = request_queue.pop_front();
               req_type <= next.kind;
               req_priority_req <= next.prio;
               req_item_in <= next.value;
               req_valid <= 1'b1;
               if (burst_left <= 1) begin
                  burst_left = $urandom_range(1, 16);
                  gap_left = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 20);
               end else begin
                  burst_left--;
               end
            end
         end
      end
   end

   // Receiver: checks each accepted response against the oldest expectation and
   // stalls on a pattern that changes mode at random intervals. Once, early
   // in the run, it holds off long enough for the block to back up its input.
   int mode = 0;
   int mode_left = 0;
   int hold_left = 0;
   bit hold_done = 1'b0;
   int phase = 0;

   always @(posedge clock) begin
      queue_response_type want;
      logic stall_next;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            responses_done <= responses_done + 1;
            if (expected_responses.size() == 0) begin
               $display("%0t ns: ERROR, response with nothing expected: item %0d status %0d",
                        $time, rsp_item_out, rsp_status);
               error_count++;
            end else begin
               want = expected_responses.pop_front();
               if (rsp_item_out !== want.item)
                  report_field("item_out", want.item, rsp_item_out);
               if (rsp_status !== want.status)
                  report_field("status", want.status, rsp_status);
               if (rsp_occupancy !== want.occupancy)
                  report_field("occupancy", want.occupancy, rsp_occupancy);
            end
         end
         if (!hold_done && responses_done >= 40) begin
            hold_done = 1'b1;
            hold_left = LONG_HOLD_CYCLES;
         end
         if (mode_left == 0) begin
            mode = $urandom_range(3);
            mode_left = $urandom_range(20, 80);
         end else begin
            mode_left--;
         end
         phase = (phase + 1) % 5;
         if (hold_left > 0) begin
            hold_left--;
            stall_next = 1'b1;
            if (req_stall) full_stall_cycles++;
         end else begin
            case (mode)
               0: stall_next = 1'b0;
               1: stall_next = ($urandom_range(99) < 25);
               2: stall_next = ($urandom_range(99) < 70);
               default: stall_next = (phase < 3);
            endcase
         end
         rsp_stall <= stall_next;
      end
   end

   // Stimulus and end of run.
   initial begin
      int random_live;
      int flavor;
      int spread;
      int run_len;
      int roll;
      int ins_cut;
      int rem_cut;
      int prio;
      logic [1:0] kind;

      // Empty queue: both reads underflow, the unused code is ignored.
      queue_up(pqa_pkg::REQ_PEEK, 8'hff, 32'hffff_ffff, 1'b0);
      queue_up(pqa_pkg::REQ_REMOVE, 0, 32'h1234_5678, 1'b0);
      queue_up(REQ_UNUSED, 8'h5a, 32'hdead_beef, 1'b0);
      // Fill all slots, with priority extremes, item extremes and ties.
      queue_up(pqa_pkg::REQ_INSERT, 0, 32'h8000_0000, 1'b0);
      queue_up(pqa_pkg::REQ_INSERT, 255, 32'h7fff_ffff, 1'b0);
      queue_up(pqa_pkg::REQ_INSERT, 255, 32'hffff_ffff, 1'b0);
      queue_up(pqa_pkg::REQ_INSERT, 7, 32'h0000_0000, 1'b0);
      queue_up(pqa_pkg::REQ_INSERT, 7, 32'h0000_0001, 1'b0);
      queue_up(pqa_pkg::REQ_INSERT, 128, 32'h5555_aaaa, 1'b0);
      queue_up(pqa_pkg::REQ_INSERT, 127, 32'haaaa_5555, 1'b0);
      queue_up(pqa_pkg::REQ_INSERT, 1, 32'h0f0f_f0f0, 1'b0);
      // Full queue: overflow, then peek and the unused code with items stored.
      queue_up(pqa_pkg::REQ_INSERT, 200, 32'h1111_1111, 1'b0);
      queue_up(pqa_pkg::REQ_PEEK, 0, 32'h0, 1'b0);
      queue_up(REQ_UNUSED, 0, 32'h0, 1'b0);
      queue_up(pqa_pkg::REQ_REMOVE, 0, 32'h0, 1'b0);
      // The freed slot 1 is reused; it now ties slot 2 and wins by index even
      // though it is the newer item.
      queue_up(pqa_pkg::REQ_INSERT, 255, 32'h1234_5678, 1'b1);
      queue_up(pqa_pkg::REQ_REMOVE, 0, 32'h0, 1'b0);
      repeat (7) queue_up(pqa_pkg::REQ_REMOVE, 0, 32'h0, 1'b0);
      queue_up(pqa_pkg::REQ_REMOVE, 0, 32'h0, 1'b0);

      // Random phases lean toward filling, draining or a balance, some with narrow
      // priority ranges to force ties, and a few unused codes as noise.
      random_live = 0;
      while (random_live < RANDOM_REQUESTS) begin
         flavor = $urandom_range(2);
         spread = $urandom_range(2);
         run_len = $urandom_range(10, 40);
         ins_cut = (flavor == 0) ? 70 : (flavor == 1) ? 25 : 45;
         rem_cut = (flavor == 0) ? 88 : 80;
         for (int n = 0; n < run_len; n++) begin
            roll = $urandom_range(99);
            if (roll < 3) kind = REQ_UNUSED;
            else if (roll < ins_cut) kind = pqa_pkg::REQ_INSERT;
            else if (roll < rem_cut) kind = pqa_pkg::REQ_REMOVE;
            else kind = pqa_pkg::REQ_PEEK;
            case (spread)
               0: prio = $urandom_range(3);
               1: prio = $urandom_range(255);
               default: prio = $urandom_range(1) ? 255 : 0;
            endcase
            queue_up(kind, prio, $urandom, (n == 0) && ($urandom_range(3) == 0));
            if (kind != REQ_UNUSED) random_live++;
         end
      end

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      while (request_queue.size() != 0 || req_valid) @(posedge clock);
      while (responses_done != sent_total) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Run covered %0d requests: %0d insert, %0d remove, %0d peek, %0d unused code.",
               sent_total, kind_tally[pqa_pkg::REQ_INSERT], kind_tally[pqa_pkg::REQ_REMOVE],
               kind_tally[pqa_pkg::REQ_PEEK], kind_tally[REQ_UNUSED]);
      $display("Overflows %0d, underflows %0d, input backed up for %0d cycles of the long hold.",
               overflow_tally, underflow_tally, full_stall_cycles);
      if (error_count == 0 && expected_responses.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest legal run.
   initial begin
      #3000000;
      $display("Timeout with %0d responses outstanding.", expected_responses.size());
      $display("Mismatches found");
      $finish;
   end

endmodule
